FILE: rtl/sjfq_pkg.sv
`default_nettype none
package sjfq_pkg;

	// Queue geometry
	localparam int DEPTH   = 16;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 8;
	localparam int KEY_W   = 16;
	localparam int ENTRY_W = KEY_W + ID_W;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POP    = 1'b1;

	// One incoming request
	typedef struct packed {
		logic             req_type;
		logic [ID_W-1:0]  job_id;
		logic [KEY_W-1:0] run_time;
	} req_t;

	// One outgoing result
	typedef struct packed {
		logic             pop_valid;
		logic             insert_dropped;
		logic [ID_W-1:0]  job_id;
		logic [KEY_W-1:0] run_time;
		logic [CNT_W-1:0] entries_held;
	} res_t;

	// Map a position in sorted order onto a storage slot of the ring
	function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
			input logic [ADDR_W-1:0] pos);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (ADDR_W+1)'(DEPTH)) begin
			sum = sum - (ADDR_W+1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sjfq_ram.sv
`default_nettype none
module sjfq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                         wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/sjfq_seq.sv
`default_nettype none
module sjfq_seq (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire  sjfq_pkg::req_t               req,
	output logic                               ready,
	input  wire                                out_free,
	output logic                               done,
	output sjfq_pkg::res_t                     res,
	output logic                               ram_we,
	output logic [sjfq_pkg::ADDR_W-1:0]        ram_waddr,
	output logic [sjfq_pkg::ENTRY_W-1:0]       ram_wdata,
	output logic [sjfq_pkg::ADDR_W-1:0]        ram_raddr,
	input  wire  [sjfq_pkg::ENTRY_W-1:0]       ram_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_POPRD = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]                      state_q, state_d;
	logic [sjfq_pkg::ADDR_W-1:0]     head_q, head_d;
	logic [sjfq_pkg::CNT_W-1:0]      count_q, count_d;
	logic [sjfq_pkg::ADDR_W-1:0]     idx_q, idx_d;
	logic [sjfq_pkg::ID_W-1:0]       job_q, job_d;
	logic [sjfq_pkg::KEY_W-1:0]      rt_q, rt_d;
	logic                            pop_valid_q, pop_valid_d;
	logic                            dropped_q, dropped_d;
	logic [sjfq_pkg::ID_W-1:0]       res_id_q, res_id_d;
	logic [sjfq_pkg::KEY_W-1:0]      res_rt_q, res_rt_d;
	logic [sjfq_pkg::CNT_W-1:0]      last_pos;
	logic [sjfq_pkg::KEY_W-1:0]      rd_key;
	logic                            key_greater;

	assign ready    = (state_q == ST_IDLE);
	assign last_pos = count_q - sjfq_pkg::CNT_W'(1);
	assign rd_key   = ram_rdata[sjfq_pkg::ENTRY_W-1:sjfq_pkg::ID_W];
	// Compare unit: stored key against the key being placed
	assign key_greater = (rd_key > rt_q);

	// Result as held for the output register
	always_comb begin
		res.pop_valid      = pop_valid_q;
		res.insert_dropped = dropped_q;
		res.job_id         = res_id_q;
		res.run_time       = res_rt_q;
		res.entries_held   = count_q;
	end

	// Sequencer: inserts walk the queue from the tail, moving larger keys up one slot; pops take the head entry
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		job_d       = job_q;
		rt_d        = rt_q;
		pop_valid_d = pop_valid_q;
		dropped_d   = dropped_q;
		res_id_d    = res_id_q;
		res_rt_d    = res_rt_q;
		done        = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = sjfq_pkg::phys_addr(head_q, idx_q);
		ram_wdata   = {rt_q, job_q};
		ram_raddr   = head_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					job_d       = req.job_id;
					rt_d        = req.run_time;
					pop_valid_d = 1'b0;
					dropped_d   = 1'b0;
					res_id_d    = '0;
					res_rt_d    = '0;
					if (req.req_type == sjfq_pkg::REQ_POP) begin
						if (count_q == '0) begin
							state_d = ST_FIN;
						end else begin
							ram_raddr = head_q;
							state_d   = ST_POPRD;
						end
					end else if (count_q == sjfq_pkg::CNT_W'(sjfq_pkg::DEPTH)) begin
						dropped_d = 1'b1;
						state_d   = ST_FIN;
					end else if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_waddr = head_q;
						ram_wdata = {req.run_time, req.job_id};
						count_d   = count_q + sjfq_pkg::CNT_W'(1);
						state_d   = ST_FIN;
					end else begin
						ram_raddr = sjfq_pkg::phys_addr(head_q,
							last_pos[sjfq_pkg::ADDR_W-1:0]);
						idx_d     = count_q[sjfq_pkg::ADDR_W-1:0];
						state_d   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ram_we    = 1'b1;
				ram_waddr = sjfq_pkg::phys_addr(head_q, idx_q);
				if (key_greater) begin
					// Move the larger entry up; fetch the next one down
					ram_wdata = ram_rdata;
					ram_raddr = sjfq_pkg::phys_addr(head_q,
						idx_q - sjfq_pkg::ADDR_W'(2));
					idx_d     = idx_q - sjfq_pkg::ADDR_W'(1);
					if (idx_q == sjfq_pkg::ADDR_W'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					// Equal or smaller key stays ahead: drop the new job in here
					ram_wdata = {rt_q, job_q};
					count_d   = count_q + sjfq_pkg::CNT_W'(1);
					state_d   = ST_FIN;
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = head_q;
				ram_wdata = {rt_q, job_q};
				count_d   = count_q + sjfq_pkg::CNT_W'(1);
				state_d   = ST_FIN;
			end
			ST_POPRD: begin
				pop_valid_d = 1'b1;
				res_id_d    = ram_rdata[sjfq_pkg::ID_W-1:0];
				res_rt_d    = rd_key;
				head_d      = sjfq_pkg::phys_addr(head_q, sjfq_pkg::ADDR_W'(1));
				count_d     = count_q - sjfq_pkg::CNT_W'(1);
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		job_q       <= job_d;
		rt_q        <= rt_d;
		pop_valid_q <= pop_valid_d;
		dropped_q   <= dropped_d;
		res_id_q    <= res_id_d;
		res_rt_q    <= res_rt_d;
	end

endmodule
`default_nettype wire

FILE: rtl/shortest_job_first_queue_unit.sv
`default_nettype none
// Shortest-job-first hold queue. Keeps up to DEPTH (16) jobs in a ring memory,
// sorted by run time with equal run times in arrival order. s_tuser picks the
// request: insert (0) or pop (1). Every request yields exactly one result item.
// An insert walks the queue from the tail, one entry per cycle through the
// memory's one read port and one write port and one key comparator, moving
// each larger entry up one slot, then writes the new job in the gap. A pop
// reads the head entry and finishes. A pop on an empty queue, an insert into
// an empty queue and an insert into a full queue go straight to finishing. A new
// request is taken only when the previous one has finished. A finished result
// waits in an output register; the next request is accepted meanwhile, but
// the sequencer holds in its last cycle until that register is taken.
module shortest_job_first_queue_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // job_id[7:0], run_time[23:8]
	input  wire  [0:0]  s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // out_job_id[7:0], out_run_time[23:8],
	                               // entries_held[28:24], zero[31:29]
	output logic [1:0]  m_tuser    // pop_valid[0], insert_dropped[1]
);

	sjfq_pkg::req_t                req;
	sjfq_pkg::res_t                res;
	sjfq_pkg::res_t                out_q;
	logic                          out_valid_q;
	logic                          seq_ready;
	logic                          seq_done;
	logic                          out_free;
	logic                          ram_we;
	logic [sjfq_pkg::ADDR_W-1:0]   ram_waddr;
	logic [sjfq_pkg::ADDR_W-1:0]   ram_raddr;
	logic [sjfq_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [sjfq_pkg::ENTRY_W-1:0]  ram_rdata;

	// Unpack request
	always_comb begin
		req.req_type = s_tuser[0];
		req.job_id   = s_tdata[7:0];
		req.run_time = s_tdata[23:8];
	end

	assign s_tready = seq_ready;
	assign out_free = !out_valid_q || m_tready;

	sjfq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && seq_ready),
		.req       (req),
		.ready     (seq_ready),
		.out_free  (out_free),
		.done      (seq_done),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	sjfq_ram #(
		.WIDTH (sjfq_pkg::ENTRY_W),
		.DEPTH (sjfq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: load a finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_q <= res;
		end
	end

	// Pack result
	assign m_tvalid = out_valid_q;
	always_comb begin
		m_tdata        = '0;
		m_tdata[7:0]   = out_q.job_id;
		m_tdata[23:8]  = out_q.run_time;
		m_tdata[28:24] = out_q.entries_held;
		m_tuser[0]     = out_q.pop_valid;
		m_tuser[1]     = out_q.insert_dropped;
	end

endmodule
`default_nettype wire

FILE: rtl/sjfq_checker.sv
`default_nettype none
module sjfq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// Take one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// Never flag a pop and a dropped insert together
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("pop and drop flagged together");

	// Zero job fields when no job is returned
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'd0)
		else $error("job fields nonzero without a popped job");

	// Keep the count within the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:24] <= 5'(sjfq_pkg::DEPTH))
		else $error("entries held exceeds depth");

endmodule

bind shortest_job_first_queue_unit sjfq_checker u_sjfq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
